>>> sv/ccc_pkg.sv
`timescale 1ns / 1ps
// shared widths, constants and stage types for the circle contact pipeline
// used by the sqrt and divide cells and by the top level
package ccc_pkg;

  localparam int POS_W    = 32;
  localparam int RAD_W    = 30;
  localparam int SUM_W    = 31;
  localparam int MAG_W    = 31;
  localparam int NRM_W    = 16;
  localparam int DEP_W    = 31;
  localparam int SQ_W     = 64;
  localparam int ROOT_W   = 32;
  localparam int REM_W    = 34;
  localparam int Q_W      = 15;
  localparam int NUM_W    = 46;
  localparam int NRM_SH   = 14;
  localparam int SQ_STEPS = 32;
  localparam int DIV_STEPS = 15;
  localparam int SHF_STEPS = 5;

  localparam logic [Q_W-1:0] NORMAL_ONE = 15'd16384;

  // one step of the bit-pair square root
  typedef struct packed {
    logic [SQ_W-1:0]   n;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_st_t;

  // one lane of the restoring divider
  typedef struct packed {
    logic [NUM_W-1:0]  rem;
    logic [ROOT_W-1:0] d;
    logic [Q_W-1:0]    q;
  } div_st_t;

  // per-item sideband carried down the chain
  typedef struct packed {
    logic [POS_W-1:0]  fx;
    logic [POS_W-1:0]  fy;
    logic [POS_W-1:0]  sx;
    logic [POS_W-1:0]  sy;
    logic [RAD_W-1:0]  fr;
    logic [RAD_W-1:0]  sr;
    logic [SUM_W-1:0]  rs;
    logic              hit;
    logic              negx;
    logic              negy;
    logic              zero;
    logic [MAG_W-1:0]  ax;
    logic [MAG_W-1:0]  ay;
    logic [ROOT_W-1:0] span;
  } ctx_t;

endpackage

>>> sv/circle_circle_contact.sv
`timescale 1ns / 1ps
// top level of the circle pair contact pipeline
// depends on ccc_pkg, ccc_sqrt_cell and ccc_div_cell
//
// Takes one circle pair per clock while in_stall is low and returns one
// result beat per pair, through 61 register stages. The stages form a
// chain of cells: a 5 step normalizing shifter, 32 square root cells
// (distance and normalized length side by side) and 15 divider cells
// per normal component, plus setup and output stages.
// The whole chain moves as one while the result beat is not stalled; a
// stalled result holds the chain and in_stall follows. A miss gives
// out_colliding low and all other fields zero.
module circle_circle_contact (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [ccc_pkg::POS_W-1:0]    in_first_x,
  input  logic signed [ccc_pkg::POS_W-1:0]    in_first_y,
  input  logic        [ccc_pkg::RAD_W-1:0]    in_first_radius,
  input  logic signed [ccc_pkg::POS_W-1:0]    in_second_x,
  input  logic signed [ccc_pkg::POS_W-1:0]    in_second_y,
  input  logic        [ccc_pkg::RAD_W-1:0]    in_second_radius,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_colliding,
  output logic signed [ccc_pkg::NRM_W-1:0]    out_normal_x,
  output logic signed [ccc_pkg::NRM_W-1:0]    out_normal_y,
  output logic signed [ccc_pkg::POS_W-1:0]    out_start_x,
  output logic signed [ccc_pkg::POS_W-1:0]    out_start_y,
  output logic signed [ccc_pkg::POS_W-1:0]    out_end_x,
  output logic signed [ccc_pkg::POS_W-1:0]    out_end_y,
  output logic        [ccc_pkg::DEP_W-1:0]    out_depth
);
  import ccc_pkg::*;

  localparam int NST = 4 + SHF_STEPS + 2 + SQ_STEPS + 1 + DIV_STEPS + 2;

  function automatic logic [POS_W-1:0] sat34(input logic [POS_W+1:0] v);
    logic neg;
    neg = v[POS_W+1];
    if (!neg && (v[POS_W+1:POS_W-1] != 3'b000)) begin
      sat34 = {1'b0, {(POS_W-1){1'b1}}};
    end else if (neg && (v[POS_W+1:POS_W-1] != 3'b111)) begin
      sat34 = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      sat34 = v[POS_W-1:0];
    end
  endfunction

  logic           adv;
  logic [NST-1:0] vld_r;

  assign adv       = !(vld_r[NST-1] && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  // setup stages: offset, magnitude, squares, hit test
  ctx_t              ctx_in;
  ctx_t              ctx1_r, ctx2_r, ctx3_r, ctx4_r;
  ctx_t              ctx2_nxt, ctx3_nxt, ctx4_nxt;
  logic [POS_W:0]    dx1_r, dy1_r;
  logic [POS_W:0]    ax2_r, ay2_r;
  logic [2*POS_W+1:0] sqx3_r, sqy3_r;
  logic [2*SUM_W-1:0] rs23_r;
  logic [2*POS_W+2:0] sum3;
  logic [2*MAG_W-1:0] dop4_r;

  always_comb begin
    ctx_in      = '0;
    ctx_in.fx   = in_first_x;
    ctx_in.fy   = in_first_y;
    ctx_in.sx   = in_second_x;
    ctx_in.sy   = in_second_y;
    ctx_in.fr   = in_first_radius;
    ctx_in.sr   = in_second_radius;
    ctx_in.rs   = SUM_W'(in_first_radius) + SUM_W'(in_second_radius);
    sum3        = (2*POS_W+3)'(sqx3_r) + (2*POS_W+3)'(sqy3_r);
  end

  // past 31 bits the pair cannot hit, so the narrow copies suffice
  always_comb begin
    ctx2_nxt      = ctx1_r;
    ctx2_nxt.negx = dx1_r[POS_W];
    ctx2_nxt.negy = dy1_r[POS_W];
    ctx3_nxt      = ctx2_r;
    ctx3_nxt.ax   = ax2_r[MAG_W-1:0];
    ctx3_nxt.ay   = ay2_r[MAG_W-1:0];
    ctx4_nxt      = ctx3_r;
    ctx4_nxt.hit  = (sum3 <= (2*POS_W+3)'(rs23_r));
    ctx4_nxt.zero = (ctx3_r.ax == '0) && (ctx3_r.ay == '0);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx1_r <= ctx_in;
      dx1_r  <= {in_second_x[POS_W-1], in_second_x} - {in_first_x[POS_W-1], in_first_x};
      dy1_r  <= {in_second_y[POS_W-1], in_second_y} - {in_first_y[POS_W-1], in_first_y};

      ctx2_r <= ctx2_nxt;
      ax2_r  <= dx1_r[POS_W] ? -dx1_r : dx1_r;
      ay2_r  <= dy1_r[POS_W] ? -dy1_r : dy1_r;

      ctx3_r <= ctx3_nxt;
      sqx3_r <= ax2_r * ax2_r;
      sqy3_r <= ay2_r * ay2_r;
      rs23_r <= ctx2_r.rs * ctx2_r.rs;

      ctx4_r <= ctx4_nxt;
      dop4_r <= sum3[2*MAG_W-1:0];
    end
  end

  // normalizing shifter cells: 16, 8, 4, 2, 1
  ctx_t               ctxs_r [SHF_STEPS];
  logic [2*MAG_W-1:0] dops_r [SHF_STEPS];

  for (genvar k = 0; k < SHF_STEPS; k++) begin : g_shf
    localparam int SH = 16 >> k;
    ctx_t               c_i;
    ctx_t               c_nxt;
    logic [2*MAG_W-1:0] d_i;
    logic [MAG_W-1:0]   both;
    if (k == 0) begin : g_first
      assign c_i = ctx4_r;
      assign d_i = dop4_r;
    end else begin : g_next
      assign c_i = ctxs_r[k-1];
      assign d_i = dops_r[k-1];
    end
    assign both = c_i.ax | c_i.ay;
    always_comb begin
      c_nxt = c_i;
      if ((both >> (MAG_W - SH)) == '0) begin
        c_nxt.ax = c_i.ax << SH;
        c_nxt.ay = c_i.ay << SH;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        ctxs_r[k] <= c_nxt;
        dops_r[k] <= d_i;
      end
    end
  end

  // squares of the normalized offset, then root cell inputs
  ctx_t               ctx10_r, ctx11_r;
  logic [2*MAG_W-1:0] dop10_r;
  logic [2*MAG_W-1:0] sqa10_r, sqb10_r;
  sqrt_st_t           dsq11_r, lsq11_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx10_r <= ctxs_r[SHF_STEPS-1];
      dop10_r <= dops_r[SHF_STEPS-1];
      sqa10_r <= ctxs_r[SHF_STEPS-1].ax * ctxs_r[SHF_STEPS-1].ax;
      sqb10_r <= ctxs_r[SHF_STEPS-1].ay * ctxs_r[SHF_STEPS-1].ay;

      ctx11_r      <= ctx10_r;
      dsq11_r.n    <= SQ_W'(dop10_r);
      dsq11_r.rem  <= '0;
      dsq11_r.root <= '0;
      lsq11_r.n    <= SQ_W'(sqa10_r) + SQ_W'(sqb10_r);
      lsq11_r.rem  <= '0;
      lsq11_r.root <= '0;
    end
  end

  // square root cells: distance and normalized length side by side
  ctx_t     ctxq_r [SQ_STEPS];
  sqrt_st_t dsq_r  [SQ_STEPS];
  sqrt_st_t lsq_r  [SQ_STEPS];

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sq
    ctx_t     c_i;
    sqrt_st_t d_i, l_i;
    if (j == 0) begin : g_first
      assign c_i = ctx11_r;
      assign d_i = dsq11_r;
      assign l_i = lsq11_r;
    end else begin : g_next
      assign c_i = ctxq_r[j-1];
      assign d_i = dsq_r[j-1];
      assign l_i = lsq_r[j-1];
    end
    ccc_sqrt_cell u_dist (.clk(clk), .adv(adv), .st_i(d_i), .st_r(dsq_r[j]));
    ccc_sqrt_cell u_len  (.clk(clk), .adv(adv), .st_i(l_i), .st_r(lsq_r[j]));
    always_ff @(posedge clk) begin
      if (adv) begin
        ctxq_r[j] <= c_i;
      end
    end
  end

  // divider setup: |c| * 2^14 + len / 2 over len
  ctx_t              ctxn_r;
  ctx_t              ctxn_nxt;
  div_st_t           dvx_n_r, dvy_n_r;
  logic [ROOT_W-1:0] len_q;

  assign len_q = lsq_r[SQ_STEPS-1].root;

  always_comb begin
    ctxn_nxt      = ctxq_r[SQ_STEPS-1];
    ctxn_nxt.span = dsq_r[SQ_STEPS-1].root;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctxn_r      <= ctxn_nxt;
      dvx_n_r.rem <= NUM_W'({ctxq_r[SQ_STEPS-1].ax, {NRM_SH{1'b0}}})
                     + NUM_W'(len_q[ROOT_W-1:1]);
      dvx_n_r.d   <= len_q;
      dvx_n_r.q   <= '0;
      dvy_n_r.rem <= NUM_W'({ctxq_r[SQ_STEPS-1].ay, {NRM_SH{1'b0}}})
                     + NUM_W'(len_q[ROOT_W-1:1]);
      dvy_n_r.d   <= len_q;
      dvy_n_r.q   <= '0;
    end
  end

  // divider cells, one quotient bit each
  ctx_t    ctxd_r [DIV_STEPS];
  div_st_t dvx_r  [DIV_STEPS];
  div_st_t dvy_r  [DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_dv
    ctx_t    c_i;
    div_st_t x_i, y_i;
    if (j == 0) begin : g_first
      assign c_i = ctxn_r;
      assign x_i = dvx_n_r;
      assign y_i = dvy_n_r;
    end else begin : g_next
      assign c_i = ctxd_r[j-1];
      assign x_i = dvx_r[j-1];
      assign y_i = dvy_r[j-1];
    end
    ccc_div_cell #(.SH(DIV_STEPS-1-j)) u_x (.clk(clk), .adv(adv), .st_i(x_i), .st_r(dvx_r[j]));
    ccc_div_cell #(.SH(DIV_STEPS-1-j)) u_y (.clk(clk), .adv(adv), .st_i(y_i), .st_r(dvy_r[j]));
    always_ff @(posedge clk) begin
      if (adv) begin
        ctxd_r[j] <= c_i;
      end
    end
  end

  // normal, radius offsets
  ctx_t               ctxp_r;
  logic [Q_W-1:0]     qx, qy;
  logic [NRM_W-1:0]   nx_r, ny_r;
  logic [NUM_W-1:0]   pxs, pys, pxf, pyf;
  logic [SUM_W-1:0]   pxs_r, pys_r, pxf_r, pyf_r;
  localparam logic [NUM_W-1:0] HALF = NUM_W'(NORMAL_ONE >> 1);

  always_comb begin
    qx = dvx_r[DIV_STEPS-1].q;
    qy = dvy_r[DIV_STEPS-1].q;
    if (qx > NORMAL_ONE) qx = NORMAL_ONE;
    if (qy > NORMAL_ONE) qy = NORMAL_ONE;
    if (ctxd_r[DIV_STEPS-1].zero) begin
      qx = '0;
      qy = '0;
    end
    pxs = NUM_W'(qx) * NUM_W'(ctxd_r[DIV_STEPS-1].sr) + HALF;
    pys = NUM_W'(qy) * NUM_W'(ctxd_r[DIV_STEPS-1].sr) + HALF;
    pxf = NUM_W'(qx) * NUM_W'(ctxd_r[DIV_STEPS-1].fr) + HALF;
    pyf = NUM_W'(qy) * NUM_W'(ctxd_r[DIV_STEPS-1].fr) + HALF;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctxp_r <= ctxd_r[DIV_STEPS-1];
      nx_r   <= ctxd_r[DIV_STEPS-1].negx ? -NRM_W'(qx) : NRM_W'(qx);
      ny_r   <= ctxd_r[DIV_STEPS-1].negy ? -NRM_W'(qy) : NRM_W'(qy);
      pxs_r  <= pxs[NRM_SH +: SUM_W];
      pys_r  <= pys[NRM_SH +: SUM_W];
      pxf_r  <= pxf[NRM_SH +: SUM_W];
      pyf_r  <= pyf[NRM_SH +: SUM_W];
    end
  end

  // contact points with saturation, output register
  logic [POS_W+1:0] stx, sty, enx, eny;
  logic [POS_W+1:0] sxe, sye, fxe, fye;
  logic             col_r;
  logic [NRM_W-1:0] onx_r, ony_r;
  logic [POS_W-1:0] osx_r, osy_r, oex_r, oey_r;
  logic [DEP_W-1:0] odp_r;

  always_comb begin
    sxe = {{2{ctxp_r.sx[POS_W-1]}}, ctxp_r.sx};
    sye = {{2{ctxp_r.sy[POS_W-1]}}, ctxp_r.sy};
    fxe = {{2{ctxp_r.fx[POS_W-1]}}, ctxp_r.fx};
    fye = {{2{ctxp_r.fy[POS_W-1]}}, ctxp_r.fy};
    stx = ctxp_r.negx ? sxe + (POS_W+2)'(pxs_r) : sxe - (POS_W+2)'(pxs_r);
    sty = ctxp_r.negy ? sye + (POS_W+2)'(pys_r) : sye - (POS_W+2)'(pys_r);
    enx = ctxp_r.negx ? fxe - (POS_W+2)'(pxf_r) : fxe + (POS_W+2)'(pxf_r);
    eny = ctxp_r.negy ? fye - (POS_W+2)'(pyf_r) : fye + (POS_W+2)'(pyf_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      col_r <= ctxp_r.hit;
      if (ctxp_r.hit) begin
        onx_r <= nx_r;
        ony_r <= ny_r;
        osx_r <= sat34(stx);
        osy_r <= sat34(sty);
        oex_r <= sat34(enx);
        oey_r <= sat34(eny);
        odp_r <= ctxp_r.rs - ctxp_r.span[DEP_W-1:0];
      end else begin
        onx_r <= '0;
        ony_r <= '0;
        osx_r <= '0;
        osy_r <= '0;
        oex_r <= '0;
        oey_r <= '0;
        odp_r <= '0;
      end
    end
  end

  assign out_colliding = col_r;
  assign out_normal_x  = onx_r;
  assign out_normal_y  = ony_r;
  assign out_start_x   = osx_r;
  assign out_start_y   = osy_r;
  assign out_end_x     = oex_r;
  assign out_end_y     = oey_r;
  assign out_depth     = odp_r;

endmodule

>>> sv/ccc_sqrt_cell.sv
`timescale 1ns / 1ps
// one cell of the pipelined integer square root: retires one root bit
// depends on ccc_pkg
module ccc_sqrt_cell (
  input  logic               clk,
  input  logic               adv,
  input  ccc_pkg::sqrt_st_t  st_i,
  output ccc_pkg::sqrt_st_t  st_r
);
  import ccc_pkg::*;

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  sqrt_st_t         st_nxt;

  always_comb begin
    rem_sh   = {st_i.rem[REM_W-3:0], st_i.n[SQ_W-1 -: 2]};
    trial    = {st_i.root, 2'b01};
    st_nxt.n = {st_i.n[SQ_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      st_nxt.rem  = rem_sh - trial;
      st_nxt.root = {st_i.root[ROOT_W-2:0], 1'b1};
    end else begin
      st_nxt.rem  = rem_sh;
      st_nxt.root = {st_i.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r <= st_nxt;
    end
  end

endmodule

>>> sv/ccc_div_cell.sv
`timescale 1ns / 1ps
// one cell of the pipelined restoring divider: retires one quotient bit
// depends on ccc_pkg
module ccc_div_cell #(
  parameter int SH = 0
) (
  input  logic              clk,
  input  logic              adv,
  input  ccc_pkg::div_st_t  st_i,
  output ccc_pkg::div_st_t  st_r
);
  import ccc_pkg::*;

  logic [NUM_W:0] trial;
  div_st_t        st_nxt;

  always_comb begin
    trial    = (NUM_W+1)'(st_i.d) << SH;
    st_nxt.d = st_i.d;
    if ({1'b0, st_i.rem} >= trial) begin
      st_nxt.rem = st_i.rem - trial[NUM_W-1:0];
      st_nxt.q   = {st_i.q[Q_W-2:0], 1'b1};
    end else begin
      st_nxt.rem = st_i.rem;
      st_nxt.q   = {st_i.q[Q_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r <= st_nxt;
    end
  end

endmodule
